// ===== rtl/glu_pkg.sv =====
// Shared types and constants for the GCD/LCM unit.
// No dependencies.
`default_nettype none
package glu_pkg;
    localparam int OpW = 32;
    localparam int ResW = 64;

    typedef enum logic {
        CMD_GCD = 1'b0,
        CMD_LCM = 1'b1
    } t_cmd;

    typedef struct packed {
        logic            cmd;
        logic [OpW-1:0]  first_operand;
        logic [OpW-1:0]  second_operand;
    } t_req;

    typedef struct packed {
        logic [ResW-1:0] result_value;
        logic            invalid;
    } t_rsp;

    typedef struct packed {
        logic            invalid;
        logic            cmd;
        logic [OpW-1:0]  a;
        logic [OpW-1:0]  b;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/glu_front.sv =====
// Front end: accepts requests, masks operands and flags invalid ones.
// Depends on glu_pkg; holds a two-entry queue toward the back end.
`default_nettype none
module glu_front #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  glu_pkg::t_req  i_req,
    output logic           o_job_valid,
    input  wire            i_job_take,
    output glu_pkg::t_job  o_job
);
    import glu_pkg::*;

    t_job         r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic [OpW-1:0] mask;
    t_job         job;
    logic         push, pop;

    assign mask = OpW'({OPERAND_WIDTH{1'b1}});
    always_comb begin
        job.cmd = i_req.cmd;
        job.a = i_req.first_operand & mask;
        job.b = i_req.second_operand & mask;
        job.invalid = (job.a == '0) || (job.b == '0);
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop = o_job_valid && i_job_take;
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/glu_back.sv =====
// Back end: bit-serial remainder unit for Euclid's loop and the LCM divide.
// Depends on glu_pkg; takes jobs from the front end queue.
`default_nettype none
module glu_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_job_valid,
    output logic           o_job_take,
    input  glu_pkg::t_job  i_job,
    output logic           o_valid,
    input  wire            i_stall,
    output glu_pkg::t_rsp  o_rsp
);
    import glu_pkg::*;

    localparam int CntW = $clog2(OpW);

    t_state          r_state, n_state;
    logic [OpW-1:0]  r_a, r_b, r_opa, r_opb, r_num, r_quo;
    logic [OpW-1:0]  r_rem;
    logic [CntW-1:0] r_cnt;
    logic            r_cmd, r_inv;
    logic [ResW-1:0] r_res;
    logic [OpW:0]    trial;
    logic            fits;
    logic            step_done;

    assign trial = {r_rem, r_num[OpW-1]};
    assign fits = trial >= {1'b0, r_b};
    assign step_done = (r_cnt == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.invalid ? ST_OUT : ST_GCD;
                end
            end
            ST_GCD: begin
                if (r_b == '0) begin
                    n_state = (r_cmd == CMD_LCM) ? ST_DIV : ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_done) n_state = (r_cmd == CMD_LCM && r_b == r_a) ? ST_MUL : ST_GCD;
            end
            ST_MUL: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_take = (r_state == ST_IDLE);
        o_valid = (r_state == ST_OUT);
        o_rsp.result_value = r_res;
        o_rsp.invalid = r_inv;
    end

    // In ST_DIV the divisor is r_b and the dividend r_num. For the final LCM
    // divide r_a equals r_b (the GCD) and r_num holds the first operand.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_a <= i_job.a;
                r_b <= i_job.b;
                r_opa <= i_job.a;
                r_opb <= i_job.b;
                r_cmd <= i_job.cmd;
                r_inv <= i_job.invalid;
                r_res <= '0;
            end
            ST_GCD: begin
                if (r_b == '0) begin
                    r_res <= {{(ResW-OpW){1'b0}}, r_a};
                    r_b <= r_a;
                    r_num <= r_opa;
                end else begin
                    r_num <= r_a;
                end
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CntW'(OpW-1);
            end
            ST_DIV: begin
                r_rem <= fits ? OpW'(trial - {1'b0, r_b}) : OpW'(trial);
                r_quo <= {r_quo[OpW-2:0], fits};
                r_num <= {r_num[OpW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (step_done && !(r_cmd == CMD_LCM && r_b == r_a)) begin
                    r_a <= r_b;
                    r_b <= fits ? OpW'(trial - {1'b0, r_b}) : OpW'(trial);
                end
            end
            ST_MUL: begin
                r_res <= ResW'(r_quo) * ResW'(r_opb);
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/gcd_lcm_unit.sv =====
// Top level of the GCD/LCM unit: front end, request queue and back end.
// Depends on glu_pkg, glu_front and glu_back.
//
// Each request yields one response. The back end runs Euclid's loop with a
// bit-serial remainder unit of one quotient bit per cycle; each remainder
// step is a setup state (ST_GCD) followed by the divide (ST_DIV). A GCD
// runs one such step per Euclid step (up to about 47 steps) between the
// back end taking the request and the output state; an LCM of unequal
// operands adds one more divide and a multiply state, and a request with a
// zero operand goes from idle straight to the output state. A two-entry
// queue lets new requests enter meanwhile.
`default_nettype none
module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  glu_pkg::t_req  i_req,
    output logic           o_valid,
    input  wire            i_stall,
    output glu_pkg::t_rsp  o_rsp
);
    import glu_pkg::*;

    t_job job;
    logic job_valid, job_take;

    glu_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req,
        .o_job_valid(job_valid), .i_job_take(job_take), .o_job(job)
    );

    glu_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_take(job_take),
        .i_job(job), .o_valid, .i_stall, .o_rsp
    );
endmodule
`default_nettype wire

// ===== rtl/glu_checker.sv =====
// Port-level checks for the GCD/LCM unit, bound to its top level.
// Depends on glu_pkg and gcd_lcm_unit.
`default_nettype none
module glu_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           o_valid,
    input wire           i_stall,
    input glu_pkg::t_rsp o_rsp
);
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.invalid |-> o_rsp.result_value == '0)
        else $error("invalid response with nonzero value");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("stalled response changed");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("back-to-back responses");
endmodule

bind gcd_lcm_unit glu_checker u_glu_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_rsp
);
`default_nettype wire

// ===== bench/tb_gcd_lcm_unit.sv =====
// Self-checking testbench for the GCD/LCM unit: random and directed requests
// are checked against a behavioral GCD/LCM calculation, with random stalls.
// Depends on glu_pkg and gcd_lcm_unit.
`default_nettype none
module tb_gcd_lcm_unit;
    import glu_pkg::*;

    localparam int NumRandom = 1750;
    localparam int WatchLimit = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int errors;
    int n_sent;
    int n_checked;
    int n_invalid;
    int n_lcm;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_phase;
    bit stim_done;
    bit req_taken;

    gcd_lcm_unit #(.OPERAND_WIDTH(32)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req(i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp(o_rsp)
    );

    function automatic t_rsp gcd_lcm_of(t_req r);
        t_rsp rsp;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        x = {32'd0, r.first_operand};
        y = {32'd0, r.second_operand};
        rsp = '0;
        if (x == 0 || y == 0) begin
            rsp.invalid = 1'b1;
        end else begin
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            if (r.cmd == CMD_GCD) begin
                rsp.result_value = x;
            end else begin
                rsp.result_value = ({32'd0, r.first_operand} / x) * r.second_operand;
            end
        end
        return rsp;
    endfunction

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 20);
            1: v = $urandom_range(1, 4096) * $urandom_range(1, 4096);
            2: v = 32'hFFFF_FFFF - $urandom_range(0, 8);
            3: v = 32'd1 << $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_req(logic cmd, logic [31:0] a, logic [31:0] b);
        t_req r;
        r.cmd = cmd;
        r.first_operand = a;
        r.second_operand = b;
        pending_reqs.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        logic [31:0] g;
        i_rst_n = 1'b0;
        for (int c = 0; c < 2; c++) begin
            add_req(c[0], 32'd0, 32'd0);
            add_req(c[0], 32'd0, 32'd7);
            add_req(c[0], 32'd9, 32'd0);
            add_req(c[0], 32'd1, 32'd1);
            add_req(c[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            add_req(c[0], 32'hFFFF_FFFF, 32'hFFFF_FFFE);
            add_req(c[0], 32'hB520_0000, 32'h0000_0001);
            add_req(c[0], 32'd2971215073, 32'd1836311903);
            add_req(c[0], 32'd12, 32'd18);
            add_req(c[0], 32'h8000_0000, 32'h4000_0000);
        end
        for (int i = 0; i < NumRandom; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                g = $urandom_range(1, 65535);
                add_req(1'($urandom_range(0, 1)), g * $urandom_range(1, 65535),
                        g * $urandom_range(1, 65535));
            end else begin
                add_req(1'($urandom_range(0, 1)), rand_operand(), rand_operand());
            end
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && !o_stall;
    end

    // Driver: bursts of requests with random gaps, changing on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_req <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (req_taken || !i_valid) begin
            if (req_taken) begin
                void'(pending_reqs.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                i_valid <= 1'b1;
                i_req <= pending_reqs[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 80);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9]) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 40) || (stall_phase[4:2] == 3'd5);
            end
        end
    end

    // Monitor: predicts on accepted requests and checks accepted responses.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        int err_now;
        bit moved;
        err_now = 0;
        moved = 1'b0;
        if (!i_rst_n) begin
            errors <= 0;
            n_sent <= 0;
            n_checked <= 0;
            n_invalid <= 0;
            n_lcm <= 0;
            idle_cycles <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_rsps.push_back(gcd_lcm_of(i_req));
                n_sent <= n_sent + 1;
                n_lcm <= n_lcm + (i_req.cmd == CMD_LCM);
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                n_checked <= n_checked + 1;
                n_invalid <= n_invalid + o_rsp.invalid;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: response with none expected: value %h invalid %b",
                             $time, o_rsp.result_value, o_rsp.invalid);
                    err_now = err_now + 1;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (exp_rsp.result_value !== o_rsp.result_value) begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, exp_rsp.result_value, o_rsp.result_value);
                        err_now = err_now + 1;
                    end
                    if (exp_rsp.invalid !== o_rsp.invalid) begin
                        $display("%0t: invalid expected %b actual %b",
                                 $time, exp_rsp.invalid, o_rsp.invalid);
                        err_now = err_now + 1;
                    end
                end
            end
            if (err_now != 0) begin
                errors <= errors + err_now;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= WatchLimit) begin
                $display("%0t: timeout, %0d responses outstanding", $time,
                         expected_rsps.size());
                $display("simulation failed");
                $finish;
            end
            if (pending_reqs.size() == 0 && !i_valid && expected_rsps.size() == 0) begin
                repeat (100) @(posedge i_clk);
                $display("Checked %0d responses to %0d requests (%0d LCM, %0d invalid).",
                         n_checked, n_sent, n_lcm, n_invalid);
                if (errors == 0 && expected_rsps.size() == 0) begin
                    $display("simulation ok");
                end else begin
                    $display("simulation failed");
                end
                $finish;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/glu_pkg.sv
rtl/glu_front.sv
rtl/glu_back.sv
rtl/gcd_lcm_unit.sv
rtl/glu_checker.sv
bench/tb_gcd_lcm_unit.sv
